[rtl/rssi_channel_scan_classifier_defines.svh]
// Assertion macros for the RSSI channel scan classifier checker.
// No dependencies; included by rscs_checker.sv.
`ifndef RSSI_CHANNEL_SCAN_CLASSIFIER_DEFINES_SVH
`define RSSI_CHANNEL_SCAN_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define RSCS_ASSERT_IMPLY(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define RSCS_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Implication that is also checked during reset.
`define RSCS_ASSERT_ALWAYS(lbl, ck, ante, cons, msg) \
    lbl: assert property (@(posedge ck) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/rscs_pkg.sv]
// Shared types, codes and constants of the RSSI channel scan classifier.
// No dependencies.
package rscs_pkg;

    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned CHANNEL_W   = 12;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned LIST_W      = 8;
    localparam int unsigned INTERVAL_W  = 10;
    localparam int unsigned TARGET_W    = 17;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 12;

    localparam logic signed [LEVEL_W-1:0] LEVEL_HIGH_RESET   = -8'sd127;
    localparam logic signed [LEVEL_W-1:0] LEVEL_LOW_RESET    = 8'sd1;
    localparam logic signed [LEVEL_W-1:0] BUSY_LIMIT_RESET   = 8'sd0;
    localparam logic signed [LEVEL_W-1:0] FREE_LIMIT_RESET   = -8'sd100;
    localparam logic [TARGET_W-1:0]       REPORTS_PER_SECOND = 17'd100;

    typedef enum logic [1:0] {
        ACT_SAMPLE       = 2'd0,
        ACT_REPORT       = 2'd1,
        ACT_CHANNEL_DONE = 2'd2,
        ACT_RESTART      = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        VERDICT_FREE     = 2'd0,
        VERDICT_POSSIBLE = 2'd1,
        VERDICT_BUSY     = 2'd2,
        VERDICT_SKIPPED  = 2'd3
    } verdict_t;

    typedef enum logic {
        KIND_INTERVAL = 1'b0,
        KIND_VERDICT  = 1'b1
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BUSY_LIMIT      = 3'd0,
        CFG_FREE_LIMIT      = 3'd1,
        CFG_STOP_ON_FREE    = 3'd2,
        CFG_PROTECTED_CHAN  = 3'd3,
        CFG_SKIP_NEIGHBOR   = 3'd4,
        CFG_INTERVAL_SEC    = 3'd5,
        CFG_NOT_MEASURED    = 3'd6
    } cfg_index_t;

    function automatic logic [COUNT_W-1:0] inc_count(input logic [COUNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic logic [LIST_W-1:0] inc_list(input logic [LIST_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

[rtl/rscs_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on rscs_pkg.
interface rscs_in_if
    import rscs_pkg::*;
();
    logic                        valid;
    logic                        ready;
    action_t                     action;
    logic signed [LEVEL_W-1:0]   rssi_sample;
    logic                        last_in_report;
    logic                        report_failed;
    logic [CHANNEL_W-1:0]        channel_number;
    logic                        neighbor_seen;

    modport source (output valid, action, rssi_sample, last_in_report, report_failed,
                    channel_number, neighbor_seen, input ready);
    modport sink   (input valid, action, rssi_sample, last_in_report, report_failed,
                    channel_number, neighbor_seen, output ready);
endinterface

interface rscs_out_if
    import rscs_pkg::*;
();
    logic                        valid;
    logic                        ready;
    kind_t                       kind;
    logic [CHANNEL_W-1:0]        channel_out;
    verdict_t                    verdict;
    logic signed [LEVEL_W-1:0]   level_high;
    logic signed [LEVEL_W-1:0]   level_low;
    logic [COUNT_W-1:0]          scans_done;
    logic [COUNT_W-1:0]          saturations;
    logic [COUNT_W-1:0]          unmeasured;
    logic [COUNT_W-1:0]          failures;
    logic [LIST_W-1:0]           list_position;
    logic                        stop_request;

    modport source (output valid, kind, channel_out, verdict, level_high, level_low,
                    scans_done, saturations, unmeasured, failures, list_position,
                    stop_request, input ready);
    modport sink   (input valid, kind, channel_out, verdict, level_high, level_low,
                    scans_done, saturations, unmeasured, failures, list_position,
                    stop_request, output ready);
endinterface

[rtl/rssi_channel_scan_classifier.sv]
// RSSI channel scan classifier: sorts samples, counts reports, gives interval events and channel verdicts.
// Depends on rscs_pkg and rscs_if.
// A result beat passes the input register, then the result register; an accepted input
// beat waits in the input register while the result register is stalled.
// Throughput: one input beat per cycle, sustained while result beats are taken.
// Reset: rst_n asynchronous, active low; clears the valid bits of both stages and all counters,
// sets the levels to their start values and the configuration registers to their defaults.
module rssi_channel_scan_classifier
    import rscs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    rscs_in_if.sink                samples,
    rscs_out_if.source             results
);

    logic signed [LEVEL_W-1:0]   busy_limit_reg;
    logic signed [LEVEL_W-1:0]   free_limit_reg;
    logic                        stop_on_free_reg;
    logic [CHANNEL_W-1:0]        protected_channel_reg;
    logic                        skip_neighbor_reg;
    logic [INTERVAL_W-1:0]       interval_seconds_reg;
    logic signed [LEVEL_W-1:0]   not_measured_reg;

    logic                        s1_valid_reg;
    action_t                     s1_action_reg;
    logic signed [LEVEL_W-1:0]   s1_sample_reg;
    logic                        s1_last_reg;
    logic                        s1_failed_reg;
    logic [CHANNEL_W-1:0]        s1_channel_reg;
    logic                        s1_neighbor_reg;

    logic signed [LEVEL_W-1:0]   running_high_reg, running_high_next;
    logic signed [LEVEL_W-1:0]   running_low_reg, running_low_next;
    logic [COUNT_W-1:0]          report_count_reg, report_count_next;
    logic [COUNT_W-1:0]          saturated_count_reg, saturated_count_next;
    logic [COUNT_W-1:0]          unmeasured_count_reg, unmeasured_count_next;
    logic [COUNT_W-1:0]          failed_count_reg, failed_count_next;
    logic [LIST_W-1:0]           free_count_reg, free_count_next;
    logic [LIST_W-1:0]           possible_count_reg, possible_count_next;
    logic [LIST_W-1:0]           busy_count_reg, busy_count_next;

    logic                        res_valid_reg;
    kind_t                       res_kind_reg, res_kind_next;
    logic [CHANNEL_W-1:0]        res_channel_reg;
    verdict_t                    res_verdict_reg, res_verdict_next;
    logic signed [LEVEL_W-1:0]   res_high_reg, res_high_next;
    logic signed [LEVEL_W-1:0]   res_low_reg, res_low_next;
    logic [COUNT_W-1:0]          res_scans_reg, res_scans_next;
    logic [COUNT_W-1:0]          res_sats_reg;
    logic [COUNT_W-1:0]          res_unmeas_reg;
    logic [COUNT_W-1:0]          res_fails_reg;
    logic [LIST_W-1:0]           res_pos_reg, res_pos_next;
    logic                        res_stop_reg, res_stop_next;
    logic                        res_emit;

    logic                        out_free;
    logic                        s1_advance;
    logic [TARGET_W-1:0]         interval_target;
    logic [COUNT_W-1:0]          report_count_inc;
    logic                        interval_hit;
    logic                        sample_saturated;
    logic                        sample_unmeasured;
    logic                        channel_protected;

    assign out_free      = !res_valid_reg || results.ready;
    assign s1_advance    = s1_valid_reg && out_free;
    assign samples.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_limit_reg        <= BUSY_LIMIT_RESET;
            free_limit_reg        <= FREE_LIMIT_RESET;
            stop_on_free_reg      <= 1'b0;
            protected_channel_reg <= '0;
            skip_neighbor_reg     <= 1'b0;
            interval_seconds_reg  <= '0;
            not_measured_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BUSY_LIMIT:     busy_limit_reg        <= cfg_data[LEVEL_W-1:0];
                CFG_FREE_LIMIT:     free_limit_reg        <= cfg_data[LEVEL_W-1:0];
                CFG_STOP_ON_FREE:   stop_on_free_reg      <= cfg_data[0];
                CFG_PROTECTED_CHAN: protected_channel_reg <= cfg_data[CHANNEL_W-1:0];
                CFG_SKIP_NEIGHBOR:  skip_neighbor_reg     <= cfg_data[0];
                CFG_INTERVAL_SEC:   interval_seconds_reg  <= cfg_data[INTERVAL_W-1:0];
                CFG_NOT_MEASURED:   not_measured_reg      <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_action_reg   <= samples.action;
            s1_sample_reg   <= samples.rssi_sample;
            s1_last_reg     <= samples.last_in_report;
            s1_failed_reg   <= samples.report_failed;
            s1_channel_reg  <= samples.channel_number;
            s1_neighbor_reg <= samples.neighbor_seen;
        end
    end

    assign interval_target   = TARGET_W'(interval_seconds_reg) * REPORTS_PER_SECOND;
    assign report_count_inc  = inc_count(report_count_reg);
    assign interval_hit      = (interval_target != '0)
                               && ({1'b0, report_count_inc} == interval_target);
    assign sample_saturated  = !s1_sample_reg[LEVEL_W-1] && (s1_sample_reg != '0);
    assign sample_unmeasured = (s1_sample_reg == not_measured_reg);
    assign channel_protected = (protected_channel_reg != '0)
                               && (s1_channel_reg == protected_channel_reg);

    always_comb
    begin
        running_high_next     = running_high_reg;
        running_low_next      = running_low_reg;
        report_count_next     = report_count_reg;
        saturated_count_next  = saturated_count_reg;
        unmeasured_count_next = unmeasured_count_reg;
        failed_count_next     = failed_count_reg;
        free_count_next       = free_count_reg;
        possible_count_next   = possible_count_reg;
        busy_count_next       = busy_count_reg;
        res_emit              = 1'b0;
        res_kind_next         = KIND_INTERVAL;
        res_verdict_next      = VERDICT_FREE;
        res_pos_next          = '0;
        res_stop_next         = 1'b0;

        unique case (s1_action_reg)
            ACT_SAMPLE:
            begin
                if (sample_saturated)
                begin
                    saturated_count_next = inc_count(saturated_count_reg);
                end
                else if (sample_unmeasured)
                begin
                    unmeasured_count_next = inc_count(unmeasured_count_reg);
                end
                else
                begin
                    if (s1_sample_reg > running_high_reg)
                    begin
                        running_high_next = s1_sample_reg;
                    end
                    if (s1_sample_reg < running_low_reg)
                    begin
                        running_low_next = s1_sample_reg;
                    end
                end
                if (s1_last_reg)
                begin
                    report_count_next = report_count_inc;
                    res_emit          = interval_hit;
                end
            end
            ACT_REPORT:
            begin
                if (s1_failed_reg)
                begin
                    failed_count_next = inc_count(failed_count_reg);
                end
                report_count_next = report_count_inc;
                res_emit          = interval_hit;
            end
            ACT_CHANNEL_DONE:
            begin
                res_emit      = 1'b1;
                res_kind_next = KIND_VERDICT;
                priority if (running_high_reg > busy_limit_reg)
                begin
                    res_verdict_next = VERDICT_BUSY;
                    res_pos_next     = busy_count_reg;
                    busy_count_next  = inc_list(busy_count_reg);
                end
                else if (running_high_reg <= free_limit_reg)
                begin
                    if (channel_protected || (s1_neighbor_reg && skip_neighbor_reg))
                    begin
                        res_verdict_next = VERDICT_SKIPPED;
                    end
                    else
                    begin
                        res_verdict_next = VERDICT_FREE;
                        res_pos_next     = free_count_reg;
                        free_count_next  = inc_list(free_count_reg);
                        res_stop_next    = stop_on_free_reg;
                    end
                end
                else
                begin
                    res_verdict_next    = VERDICT_POSSIBLE;
                    res_pos_next        = possible_count_reg;
                    possible_count_next = inc_list(possible_count_reg);
                end
                running_high_next = LEVEL_HIGH_RESET;
                running_low_next  = LEVEL_LOW_RESET;
                report_count_next = '0;
            end
            ACT_RESTART:
            begin
                running_high_next     = LEVEL_HIGH_RESET;
                running_low_next      = LEVEL_LOW_RESET;
                report_count_next     = '0;
                saturated_count_next  = '0;
                unmeasured_count_next = '0;
                failed_count_next     = '0;
                free_count_next       = '0;
                possible_count_next   = '0;
                busy_count_next       = '0;
            end
            default: ;
        endcase

        // Verdicts report the levels before the per-channel clear.
        res_high_next  = (s1_action_reg == ACT_CHANNEL_DONE) ? running_high_reg
                                                             : running_high_next;
        res_low_next   = (s1_action_reg == ACT_CHANNEL_DONE) ? running_low_reg
                                                             : running_low_next;
        res_scans_next = (s1_action_reg == ACT_CHANNEL_DONE) ? report_count_reg
                                                             : report_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_high_reg     <= LEVEL_HIGH_RESET;
            running_low_reg      <= LEVEL_LOW_RESET;
            report_count_reg     <= '0;
            saturated_count_reg  <= '0;
            unmeasured_count_reg <= '0;
            failed_count_reg     <= '0;
            free_count_reg       <= '0;
            possible_count_reg   <= '0;
            busy_count_reg       <= '0;
        end
        else if (s1_advance)
        begin
            running_high_reg     <= running_high_next;
            running_low_reg      <= running_low_next;
            report_count_reg     <= report_count_next;
            saturated_count_reg  <= saturated_count_next;
            unmeasured_count_reg <= unmeasured_count_next;
            failed_count_reg     <= failed_count_next;
            free_count_reg       <= free_count_next;
            possible_count_reg   <= possible_count_next;
            busy_count_reg       <= busy_count_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            res_valid_reg <= res_emit;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && res_emit)
        begin
            res_kind_reg    <= res_kind_next;
            res_channel_reg <= (res_kind_next == KIND_VERDICT) ? s1_channel_reg : '0;
            res_verdict_reg <= res_verdict_next;
            res_high_reg    <= res_high_next;
            res_low_reg     <= res_low_next;
            res_scans_reg   <= res_scans_next;
            res_sats_reg    <= saturated_count_next;
            res_unmeas_reg  <= unmeasured_count_next;
            res_fails_reg   <= failed_count_next;
            res_pos_reg     <= res_pos_next;
            res_stop_reg    <= res_stop_next;
        end
    end

    assign results.valid         = res_valid_reg;
    assign results.kind          = res_kind_reg;
    assign results.channel_out   = res_channel_reg;
    assign results.verdict       = res_verdict_reg;
    assign results.level_high    = res_high_reg;
    assign results.level_low     = res_low_reg;
    assign results.scans_done    = res_scans_reg;
    assign results.saturations   = res_sats_reg;
    assign results.unmeasured    = res_unmeas_reg;
    assign results.failures      = res_fails_reg;
    assign results.list_position = res_pos_reg;
    assign results.stop_request  = res_stop_reg;

endmodule

[rtl/rscs_checker.sv]
// Port-level assertion checker for the RSSI channel scan classifier, with its bind.
// Depends on rscs_pkg and rssi_channel_scan_classifier_defines.svh.
`include "rssi_channel_scan_classifier_defines.svh"

module rscs_checker
    import rscs_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input kind_t                kind,
    input logic [CHANNEL_W-1:0] channel_out,
    input verdict_t             verdict,
    input logic [LIST_W-1:0]    list_position,
    input logic                 stop_request
);

    `RSCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(verdict) && $stable(channel_out) && $stable(list_position), "result beat changed while stalled")

    `RSCS_ASSERT_IMPLY(a_interval_fields, clk, rst_n, out_valid && (kind == KIND_INTERVAL), (channel_out == '0) && (verdict == VERDICT_FREE) && (list_position == '0) && !stop_request, "interval event carries verdict fields")

    `RSCS_ASSERT_IMPLY(a_stop_on_free, clk, rst_n, out_valid && stop_request, (kind == KIND_VERDICT) && (verdict == VERDICT_FREE), "stop request without a free verdict")

    `RSCS_ASSERT_IMPLY(a_result_has_source, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result beat without an input beat two cycles before")

    `RSCS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid, "result valid during reset")

endmodule

bind rssi_channel_scan_classifier rscs_checker u_rscs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .kind          (results.kind),
    .channel_out   (results.channel_out),
    .verdict       (results.verdict),
    .list_position (results.list_position),
    .stop_request  (results.stop_request)
);

[sim/rssi_channel_scan_classifier_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for rssi_channel_scan_classifier: directed table and random
// phases, scored against an in-line predictor.
// Depends on rscs_pkg, rscs_if and the classifier RTL.
module rssi_channel_scan_classifier_test;
    import rscs_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int IDLE_MAX   = 17;

    typedef struct {
        action_t                   action;
        logic signed [LEVEL_W-1:0] rssi;
        logic                      last;
        logic                      failed;
        logic [CHANNEL_W-1:0]      chan;
        logic                      nbr;
    } scan_beat_t;

    typedef struct {
        kind_t                     kind;
        logic [CHANNEL_W-1:0]      chan;
        verdict_t                  verdict;
        logic signed [LEVEL_W-1:0] high;
        logic signed [LEVEL_W-1:0] low;
        logic [COUNT_W-1:0]        scans;
        logic [COUNT_W-1:0]        sats;
        logic [COUNT_W-1:0]        unmeas;
        logic [COUNT_W-1:0]        fails;
        logic [LIST_W-1:0]         pos;
        logic                      stop;
    } scan_report_t;

    typedef struct {
        logic signed [LEVEL_W-1:0] busy_lvl;
        logic signed [LEVEL_W-1:0] free_lvl;
        logic                      stop_on_free;
        logic [CHANNEL_W-1:0]      protect_chan;
        logic                      skip_nbr;
        logic [INTERVAL_W-1:0]     interval_sec;
        logic signed [LEVEL_W-1:0] unmeas_code;
    } setup_t;

    typedef struct {
        bit           is_setup;
        setup_t       setup;
        scan_beat_t   beat;
        bit           typed;
        scan_report_t want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    rscs_in_if  samples_ch ();
    rscs_out_if results_ch ();

    rssi_channel_scan_classifier uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_ch),
        .results   (results_ch)
    );

    setup_t                    setup;
    logic signed [LEVEL_W-1:0] run_high;
    logic signed [LEVEL_W-1:0] run_low;
    logic [COUNT_W-1:0]        report_cnt;
    logic [COUNT_W-1:0]        sat_cnt;
    logic [COUNT_W-1:0]        unmeas_cnt;
    logic [COUNT_W-1:0]        fail_cnt;
    logic [LIST_W-1:0]         free_cnt;
    logic [LIST_W-1:0]         possible_cnt;
    logic [LIST_W-1:0]         busy_cnt;

    scan_report_t awaited_q[$];
    plan_row_t    plan[$];
    int           errors = 0;
    int           beats_in = 0;
    int           verdicts_seen = 0;
    int           events_seen = 0;
    int           stall_left = 0;
    bit           calm = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [COUNT_W-1:0] sat_inc16(input logic [COUNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic [LIST_W-1:0] sat_inc8(input logic [LIST_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic void clear_channel();
        run_high   = LEVEL_HIGH_RESET;
        run_low    = LEVEL_LOW_RESET;
        report_cnt = '0;
    endfunction

    function automatic void clear_all();
        clear_channel();
        sat_cnt      = '0;
        unmeas_cnt   = '0;
        fail_cnt     = '0;
        free_cnt     = '0;
        possible_cnt = '0;
        busy_cnt     = '0;
    endfunction

    function automatic scan_report_t snapshot(input kind_t k, input logic [CHANNEL_W-1:0] ch,
                                              input verdict_t v, input logic [LIST_W-1:0] pos,
                                              input logic stop);
        scan_report_t r;
        r.kind    = k;
        r.chan    = ch;
        r.verdict = v;
        r.high    = run_high;
        r.low     = run_low;
        r.scans   = report_cnt;
        r.sats    = sat_cnt;
        r.unmeas  = unmeas_cnt;
        r.fails   = fail_cnt;
        r.pos     = pos;
        r.stop    = stop;
        return r;
    endfunction

    function automatic bit count_report(output scan_report_t r);
        int target;
        target     = int'(setup.interval_sec) * int'(REPORTS_PER_SECOND);
        report_cnt = sat_inc16(report_cnt);
        if (target != 0 && int'(report_cnt) == target)
        begin
            r = snapshot(KIND_INTERVAL, '0, VERDICT_FREE, '0, 1'b0);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit classify(input scan_beat_t b, output scan_report_t r);
        verdict_t          v;
        logic [LIST_W-1:0] pos;
        logic              stop;
        pos  = '0;
        stop = 1'b0;
        case (b.action)
            ACT_SAMPLE:
            begin
                if (b.rssi > 0)
                    sat_cnt = sat_inc16(sat_cnt);
                else if (b.rssi == setup.unmeas_code)
                    unmeas_cnt = sat_inc16(unmeas_cnt);
                else
                begin
                    if (b.rssi > run_high)
                        run_high = b.rssi;
                    if (b.rssi < run_low)
                        run_low = b.rssi;
                end
                if (b.last)
                    return count_report(r);
                return 1'b0;
            end
            ACT_REPORT:
            begin
                if (b.failed)
                    fail_cnt = sat_inc16(fail_cnt);
                return count_report(r);
            end
            ACT_CHANNEL_DONE:
            begin
                if (run_high > setup.busy_lvl)
                begin
                    v        = VERDICT_BUSY;
                    pos      = busy_cnt;
                    busy_cnt = sat_inc8(busy_cnt);
                end
                else if (run_high <= setup.free_lvl)
                begin
                    if ((setup.protect_chan != '0 && b.chan == setup.protect_chan)
                        || (b.nbr && setup.skip_nbr))
                        v = VERDICT_SKIPPED;
                    else
                    begin
                        v        = VERDICT_FREE;
                        pos      = free_cnt;
                        free_cnt = sat_inc8(free_cnt);
                        stop     = setup.stop_on_free;
                    end
                end
                else
                begin
                    v            = VERDICT_POSSIBLE;
                    pos          = possible_cnt;
                    possible_cnt = sat_inc8(possible_cnt);
                end
                r = snapshot(KIND_VERDICT, b.chan, v, pos, stop);
                clear_channel();
                return 1'b1;
            end
            default:
            begin
                clear_all();
                return 1'b0;
            end
        endcase
    endfunction

    function automatic scan_beat_t mk(input action_t a, input int rssi, input bit last,
                                      input bit failed, input int chan, input bit nbr);
        scan_beat_t b;
        b.action = a;
        b.rssi   = LEVEL_W'(rssi);
        b.last   = last;
        b.failed = failed;
        b.chan   = CHANNEL_W'(chan);
        b.nbr    = nbr;
        return b;
    endfunction

    function automatic scan_report_t expect_verdict(input int chan, input verdict_t v,
                                                    input int high, input int low,
                                                    input int scans, input int sats,
                                                    input int unmeas, input int fails,
                                                    input int pos, input bit stop);
        scan_report_t r;
        r.kind    = KIND_VERDICT;
        r.chan    = CHANNEL_W'(chan);
        r.verdict = v;
        r.high    = LEVEL_W'(high);
        r.low     = LEVEL_W'(low);
        r.scans   = COUNT_W'(scans);
        r.sats    = COUNT_W'(sats);
        r.unmeas  = COUNT_W'(unmeas);
        r.fails   = COUNT_W'(fails);
        r.pos     = LIST_W'(pos);
        r.stop    = stop;
        return r;
    endfunction

    function automatic setup_t mk_setup(input int busy_lvl, input int free_lvl, input bit stop,
                                        input int prot, input bit skip, input int interval,
                                        input int unmeas);
        setup_t s;
        s.busy_lvl     = LEVEL_W'(busy_lvl);
        s.free_lvl     = LEVEL_W'(free_lvl);
        s.stop_on_free = stop;
        s.protect_chan = CHANNEL_W'(prot);
        s.skip_nbr     = skip;
        s.interval_sec = INTERVAL_W'(interval);
        s.unmeas_code  = LEVEL_W'(unmeas);
        return s;
    endfunction

    function automatic logic signed [LEVEL_W-1:0] any_level();
        case ($urandom_range(0, 3))
            0:       return -8'sd128;
            1:       return 8'sd127;
            default: return LEVEL_W'($urandom);
        endcase
    endfunction

    function automatic setup_t random_setup();
        setup_t s;
        s.busy_lvl     = any_level();
        s.free_lvl     = any_level();
        s.stop_on_free = 1'($urandom);
        case ($urandom_range(0, 3))
            0:       s.protect_chan = '0;
            1:       s.protect_chan = '1;
            default: s.protect_chan = CHANNEL_W'($urandom);
        endcase
        s.skip_nbr     = 1'($urandom);
        s.interval_sec = ($urandom_range(0, 2) == 0) ? INTERVAL_W'($urandom_range(0, 655)) : '0;
        case ($urandom_range(0, 2))
            0:       s.unmeas_code = -8'sd128;
            1:       s.unmeas_code = '0;
            default: s.unmeas_code = LEVEL_W'(0 - $urandom_range(0, 128));
        endcase
        return s;
    endfunction

    function automatic scan_beat_t random_beat(input int done_pct, input int restart_pct);
        scan_beat_t b;
        int         roll;
        b.rssi   = LEVEL_W'($urandom);
        b.last   = 1'($urandom);
        b.failed = 1'($urandom);
        b.chan   = CHANNEL_W'($urandom);
        b.nbr    = 1'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < restart_pct)
            b.action = ACT_RESTART;
        else if (roll < restart_pct + done_pct)
            b.action = ACT_CHANNEL_DONE;
        else if (roll < restart_pct + done_pct + 15)
            b.action = ACT_REPORT;
        else
            b.action = ACT_SAMPLE;
        if (b.action == ACT_SAMPLE)
        begin
            roll = $urandom_range(0, 15);
            if (roll < 2)
                b.rssi = setup.unmeas_code;
            else if (roll == 2)
                b.rssi = -8'sd128;
            else if (roll == 3)
                b.rssi = 8'sd127;
            else if (roll < 6)
                b.rssi = LEVEL_W'($urandom_range(1, 127));
            else
                b.rssi = LEVEL_W'(0 - $urandom_range(0, 128));
        end
        else if (b.action == ACT_CHANNEL_DONE)
        begin
            roll = $urandom_range(0, 7);
            if (roll < 2)
                b.chan = setup.protect_chan;
            else if (roll == 2)
                b.chan = '0;
            else if (roll == 3)
                b.chan = '1;
        end
        return b;
    endfunction

    function automatic void plan_beat(input scan_beat_t b, input bit typed,
                                      input scan_report_t want);
        plan_row_t row;
        row.is_setup = 1'b0;
        row.beat     = b;
        row.typed    = typed;
        row.want     = want;
        plan.push_back(row);
    endfunction

    function automatic void plan_setup(input setup_t s);
        plan_row_t row;
        row.is_setup = 1'b1;
        row.setup    = s;
        row.typed    = 1'b0;
        plan.push_back(row);
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value, input int width);
        logic [CFG_DATA_W-1:0] mask;
        mask      = (CFG_DATA_W'(1) << width) - 1'b1;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (CFG_DATA_W'($urandom) & ~mask) | (value & mask);
        @(posedge clk);
    endtask

    task automatic apply_setup(input setup_t s);
        setup = s;
        write_reg(CFG_BUSY_LIMIT, CFG_DATA_W'(s.busy_lvl), LEVEL_W);
        write_reg(CFG_FREE_LIMIT, CFG_DATA_W'(s.free_lvl), LEVEL_W);
        write_reg(CFG_STOP_ON_FREE, CFG_DATA_W'(s.stop_on_free), 1);
        write_reg(CFG_PROTECTED_CHAN, CFG_DATA_W'(s.protect_chan), CHANNEL_W);
        write_reg(CFG_SKIP_NEIGHBOR, CFG_DATA_W'(s.skip_nbr), 1);
        write_reg(CFG_INTERVAL_SEC, CFG_DATA_W'(s.interval_sec), INTERVAL_W);
        write_reg(CFG_NOT_MEASURED, CFG_DATA_W'(s.unmeas_code), LEVEL_W);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom), CFG_DATA_W);
        cfg_we <= 1'b0;
    endtask

    task automatic pause_input(input int n);
        samples_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // drop valid, wait out every pending result, then let the pipeline empty
    task automatic settle();
        samples_ch.valid <= 1'b0;
        while (awaited_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_beat(input scan_beat_t b, input bit typed, input scan_report_t want);
        scan_report_t r;
        samples_ch.valid          <= 1'b1;
        samples_ch.action         <= b.action;
        samples_ch.rssi_sample    <= b.rssi;
        samples_ch.last_in_report <= b.last;
        samples_ch.report_failed  <= b.failed;
        samples_ch.channel_number <= b.chan;
        samples_ch.neighbor_seen  <= b.nbr;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        beats_in++;
        if (classify(b, r))
            awaited_q.push_back(typed ? want : r);
    endtask

    initial
    begin : result_pacing
        results_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                results_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                results_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, IDLE_MAX - 1);
            end
            else
                results_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        scan_report_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (awaited_q.size() == 0)
            begin
                $display("%0t: result beat expected none got kind %0d channel %0d verdict %0d",
                         $time, results_ch.kind, results_ch.channel_out, results_ch.verdict);
                errors++;
            end
            else
            begin
                want = awaited_q.pop_front();
                if (results_ch.kind == KIND_VERDICT)
                    verdicts_seen++;
                else
                    events_seen++;
                check_field("kind", want.kind, results_ch.kind);
                check_field("channel_out", want.chan, results_ch.channel_out);
                check_field("verdict", want.verdict, results_ch.verdict);
                check_field("level_high", want.high, results_ch.level_high);
                check_field("level_low", want.low, results_ch.level_low);
                check_field("scans_done", want.scans, results_ch.scans_done);
                check_field("saturations", want.sats, results_ch.saturations);
                check_field("unmeasured", want.unmeas, results_ch.unmeasured);
                check_field("failures", want.fails, results_ch.failures);
                check_field("list_position", want.pos, results_ch.list_position);
                check_field("stop_request", want.stop, results_ch.stop_request);
            end
        end
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("[rssi_channel_scan_classifier] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        scan_report_t none;
        setup_t       s;
        int           done_pct;
        int           restart_pct;
        int           n;

        rst_n                     = 1'b0;
        cfg_we                    = 1'b0;
        cfg_index                 = '0;
        cfg_data                  = '0;
        samples_ch.valid          = 1'b0;
        samples_ch.action         = ACT_SAMPLE;
        samples_ch.rssi_sample    = '0;
        samples_ch.last_in_report = 1'b0;
        samples_ch.report_failed  = 1'b0;
        samples_ch.channel_number = '0;
        samples_ch.neighbor_seen  = 1'b0;
        setup = mk_setup(BUSY_LIMIT_RESET, FREE_LIMIT_RESET, 1'b0, 0, 1'b0, 0, 0);
        clear_all();
        none = expect_verdict(0, VERDICT_FREE, 0, 0, 0, 0, 0, 0, 0, 1'b0);

        // reset defaults: busy above 0, free at or below -100, not-measured code 0
        plan_beat(mk(ACT_CHANNEL_DONE, 0, 0, 0, 0, 0), 1'b1,
                  expect_verdict(0, VERDICT_FREE, -127, 1, 0, 0, 0, 0, 0, 1'b0));
        plan_beat(mk(ACT_SAMPLE, 127, 0, 0, 0, 0), 1'b0, none);
        plan_beat(mk(ACT_SAMPLE, 0, 0, 0, 0, 0), 1'b0, none);
        plan_beat(mk(ACT_SAMPLE, -128, 1, 0, 0, 0), 1'b0, none);
        plan_beat(mk(ACT_REPORT, 127, 1, 1, 0, 0), 1'b0, none);
        plan_beat(mk(ACT_REPORT, 0, 0, 0, 0, 0), 1'b0, none);
        plan_beat(mk(ACT_SAMPLE, -1, 0, 1, 4095, 1), 1'b0, none);
        plan_beat(mk(ACT_CHANNEL_DONE, 100, 1, 1, 4095, 1), 1'b1,
                  expect_verdict(4095, VERDICT_POSSIBLE, -1, -128, 3, 1, 1, 1, 0, 1'b0));
        plan_beat(mk(ACT_RESTART, 127, 1, 1, 4095, 1), 1'b0, none);
        plan_beat(mk(ACT_CHANNEL_DONE, 0, 0, 0, 12'hAAA, 1), 1'b1,
                  expect_verdict(12'hAAA, VERDICT_FREE, -127, 1, 0, 0, 0, 0, 0, 1'b0));

        // protected channel, neighbor skip, stop request, levels equal to both limits
        plan_setup(mk_setup(-50, -80, 1'b1, 7, 1'b1, 0, -128));
        plan_beat(mk(ACT_SAMPLE, -128, 0, 0, 0, 0), 1'b0, none);
        plan_beat(mk(ACT_SAMPLE, -40, 1, 0, 0, 0), 1'b0, none);
        plan_beat(mk(ACT_CHANNEL_DONE, 0, 0, 0, 3, 0), 1'b0, none);
        plan_beat(mk(ACT_SAMPLE, -90, 1, 0, 0, 0), 1'b0, none);
        plan_beat(mk(ACT_CHANNEL_DONE, 0, 0, 0, 7, 0), 1'b0, none);
        plan_beat(mk(ACT_SAMPLE, -90, 0, 0, 0, 0), 1'b0, none);
        plan_beat(mk(ACT_CHANNEL_DONE, 0, 0, 0, 5, 1), 1'b0, none);
        plan_beat(mk(ACT_SAMPLE, -80, 0, 0, 0, 0), 1'b0, none);
        plan_beat(mk(ACT_CHANNEL_DONE, 0, 0, 0, 5, 0), 1'b0, none);
        plan_beat(mk(ACT_SAMPLE, -50, 1, 0, 0, 0), 1'b0, none);
        plan_beat(mk(ACT_CHANNEL_DONE, 0, 0, 0, 9, 1), 1'b0, none);

        // protected channel 0 protects nothing, channel 0 included
        plan_setup(mk_setup(127, 127, 1'b1, 0, 1'b0, 0, -1));
        plan_beat(mk(ACT_SAMPLE, -1, 1, 0, 0, 0), 1'b0, none);
        plan_beat(mk(ACT_CHANNEL_DONE, 0, 0, 0, 0, 1), 1'b0, none);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_setup)
            begin
                settle();
                apply_setup(plan[i].setup);
            end
            else
            begin
                if ($urandom_range(0, 5) == 0)
                    pause_input($urandom_range(1, IDLE_MAX));
                push_beat(plan[i].beat, plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; p < 5; p++)
        begin
            s           = random_setup();
            done_pct    = 12;
            restart_pct = 3;
            n           = 55;
            // hold one channel open long enough to reach the one-second interval
            if (p == 2)
            begin
                s.interval_sec = 1;
                done_pct       = 0;
                restart_pct    = 0;
                n              = 200;
            end
            settle();
            apply_setup(s);
            // run the last setup with no idling on either side
            if (p == 4)
                calm = 1'b1;
            for (int k = 0; k < n; k++)
            begin
                if (!calm && $urandom_range(0, 5) == 0)
                    pause_input($urandom_range(1, IDLE_MAX));
                push_beat(random_beat(done_pct, restart_pct), 1'b0, none);
            end
        end

        settle();
        $display("Ran %0d input beats: directed table, then random setups with idling.",
                 beats_in);
        $display("Scored %0d verdicts and %0d interval events, %0d mismatches.",
                 verdicts_seen, events_seen, errors);
        if (errors == 0)
            $display("[rssi_channel_scan_classifier] OK");
        else
            $display("[rssi_channel_scan_classifier] ERROR");
        $finish;
    end

endmodule
